// File: rtl/core/octal_counter_display_controller_defines.svh
// Assertion macros for the octal counter display controller.
// Used by the top level only; no other dependencies.
`ifndef OCTAL_COUNTER_DISPLAY_CONTROLLER_DEFINES_SVH
`define OCTAL_COUNTER_DISPLAY_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OCDC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define OCDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ocdc_pkg.sv
// Shared types, switch codes and segment table for the octal counter display controller.
// No dependencies.
package ocdc_pkg;

   localparam int DIGITS_DEFAULT = 4;

   localparam logic [2:0] DIGIT_MAX = 3'd7;

   localparam logic [7:0] SW_STOP        = 8'h00;
   localparam logic [7:0] SW_SELECT      = 8'h80;
   localparam logic [7:0] SW_SELECT_LAST = 8'h83;
   localparam logic [7:0] SW_FILL        = 8'h88;
   localparam logic [7:0] SW_SET_FIRST   = 8'h90;
   localparam logic [7:0] SW_SET_LAST    = 8'h93;
   localparam logic [7:0] SW_VALUE_LAST  = 8'h97;
   localparam logic [7:0] SW_UP          = 8'hC0;
   localparam logic [7:0] SW_DOWN        = 8'hE0;

   localparam logic       CMD_TICK  = 1'b0;
   localparam logic       CMD_WRITE = 1'b1;

   localparam logic [6:0] SEG_BLANK = 7'h00;

   typedef enum logic [6:0] {
      MODE_NONE   = 7'b0000001,
      MODE_STOP   = 7'b0000010,
      MODE_SELECT = 7'b0000100,
      MODE_SET    = 7'b0001000,
      MODE_UP     = 7'b0010000,
      MODE_DOWN   = 7'b0100000,
      MODE_FILL   = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] switch_value;
   } req_type;

   typedef struct packed {
      logic [6:0] left_segments;
      logic [6:0] right_segments;
      logic [7:0] switch_readback;
   } rsp_type;

   typedef struct packed {
      mode_type   mode;
      logic       blink_phase;
      logic [1:0] blink_steps;
      logic       first_start;
      logic [1:0] selected_digit;
      logic [7:0] switch_byte;
      logic [6:0] left_pattern;
      logic [6:0] right_pattern;
   } ctrl_type;

   function automatic logic [6:0] seg_of(input logic [2:0] value);
      logic [6:0] seg;
      unique case (value)
         3'd0: seg = 7'h3F;
         3'd1: seg = 7'h06;
         3'd2: seg = 7'h5B;
         3'd3: seg = 7'h4F;
         3'd4: seg = 7'h66;
         3'd5: seg = 7'h6D;
         3'd6: seg = 7'h7D;
         default: seg = 7'h07;
      endcase
      return seg;
   endfunction

endpackage

// File: rtl/core/octal_counter_display_controller.sv
// Four-digit octal counter with switch-byte control and two seven-segment displays.
// Depends on ocdc_pkg, ocdc_step and octal_counter_display_controller_defines.svh.
//
// Usage:
//   req channel: one request carries cmd and switch_value. cmd write stores the
//   switch byte; cmd tick decodes the switch byte into a mode and runs it.
//   rsp channel: exactly one response per request, in order, with both display
//   patterns and the switch byte as they stand after that request.
// Order: a request is registered in the input register on acceptance; its response is
//   registered in the response register when the request advances, which waits while a response is held.
// Throughput: one request per cycle while rsp_ready keeps up; the state loop closes through the single
//   update stage between the input register and the response register.
// Reset: digits, selection and switch byte clear, blink phase sets, displays
//   blank; both pipeline slots are emptied.
// Stall: while rsp_ready is low a waiting response holds, one more request
//   may sit in the input register, and req_ready drops after that.
`include "octal_counter_display_controller_defines.svh"

module octal_counter_display_controller #(
   parameter int NumDigits = ocdc_pkg::DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ocdc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ocdc_pkg::rsp_type rsp_data
);
   import ocdc_pkg::*;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   req_type                   in_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_ff;
   ctrl_type                  ctrl_ff;
   ctrl_type                  ctrl_in;
   logic [NumDigits-1:0][2:0] digits_ff;
   logic [NumDigits-1:0][2:0] digits_in;
   logic                      advance;
   logic                      req_accept;

   ocdc_step #(
      .NumDigits (NumDigits)
   ) u_step (
      .req         (in_ff),
      .ctrl        (ctrl_ff),
      .digits      (digits_ff),
      .ctrl_next   (ctrl_in),
      .digits_next (digits_in)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_accept   = req_valid && req_ready;
   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         digits_ff    <= '0;
         ctrl_ff      <= '{mode:           MODE_NONE,
                           blink_phase:    1'b1,
                           blink_steps:    2'd0,
                           first_start:    1'b0,
                           selected_digit: 2'd0,
                           switch_byte:    8'h00,
                           left_pattern:   SEG_BLANK,
                           right_pattern:  SEG_BLANK};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ctrl_ff   <= ctrl_in;
            digits_ff <= digits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= '{left_segments:   ctrl_in.left_pattern,
                     right_segments:  ctrl_in.right_pattern,
                     switch_readback: ctrl_in.switch_byte};
      end
   end

   `OCDC_ASSERT_IMPLY(a_steps_below_three, clock, reset, 1'b1,
      ctrl_ff.blink_steps != 2'd3, "blink step count reached three")
   `OCDC_ASSERT_IMPLY(a_selected_in_range, clock, reset, 1'b1,
      int'(ctrl_ff.selected_digit) < NumDigits, "selected digit out of range")
   `OCDC_ASSERT_NEXT(a_rsp_loaded, clock, reset, advance, rsp_valid_ff,
      "advanced request gave no response")
   `OCDC_ASSERT_NEXT(a_rsp_matches_state, clock, reset, advance,
      rsp_ff.switch_readback == ctrl_ff.switch_byte && rsp_ff.left_segments == ctrl_ff.left_pattern,
      "response disagrees with state")

endmodule

// File: rtl/core/ocdc_step.sv
// Next-state logic for one request: switch write or tick with mode decode and action.
// Depends on ocdc_pkg.
module ocdc_step #(
   parameter int NumDigits = ocdc_pkg::DIGITS_DEFAULT
) (
   input  ocdc_pkg::req_type             req,
   input  ocdc_pkg::ctrl_type            ctrl,
   input  logic [NumDigits-1:0][2:0]     digits,
   output ocdc_pkg::ctrl_type            ctrl_next,
   output logic [NumDigits-1:0][2:0]     digits_next
);
   import ocdc_pkg::*;

   always_comb begin
      ctrl_type                  c;
      logic [NumDigits-1:0][2:0] d;
      logic [7:0]                s;
      logic                      carry;
      logic                      wrap;
      logic                      found;
      logic                      up;
      logic [2:0]                sel_value;
      logic [1:0]                steps;

      c         = ctrl;
      d         = digits;
      s         = ctrl.switch_byte;
      carry     = 1'b1;
      wrap      = 1'b0;
      found     = 1'b0;
      up        = 1'b0;
      sel_value = 3'd0;
      steps     = 2'd0;

      if (req.cmd == CMD_WRITE) begin
         c.switch_byte = req.switch_value;
      end else begin
         // decode the switch byte
         unique case (s) inside
            SW_STOP: c.mode = MODE_STOP;
            SW_SELECT: begin
               if (!ctrl.first_start) begin
                  c.left_pattern  = seg_of(3'd0);
                  c.right_pattern = seg_of(3'd0);
                  c.first_start   = 1'b1;
                  d               = '0;
               end
               c.mode = MODE_SELECT;
            end
            [SW_SET_FIRST:SW_SET_LAST]: c.mode = MODE_SET;
            SW_UP:   c.mode = MODE_UP;
            SW_DOWN: c.mode = MODE_DOWN;
            SW_FILL: c.mode = MODE_FILL;
            default: c.mode = ctrl.mode;
         endcase

         unique case (c.mode)
            MODE_SELECT: begin
               if (s >= SW_SELECT && s <= SW_SELECT_LAST && int'(s[1:0]) < NumDigits) begin
                  c.selected_digit = s[1:0];
               end
               if (!ctrl.blink_phase) begin
                  c.left_pattern = SEG_BLANK;
                  c.blink_phase  = 1'b1;
               end else begin
                  c.left_pattern = seg_of({1'b0, c.selected_digit});
                  c.blink_phase  = 1'b0;
               end
            end
            MODE_SET: begin
               for (int j = 0; j < NumDigits; j++) begin
                  if (j == int'(c.selected_digit)) begin
                     if (s >= SW_SET_FIRST && s <= SW_VALUE_LAST) begin
                        d[j] = s[2:0];
                     end
                     sel_value = d[j];
                  end
               end
               c.left_pattern = seg_of({1'b0, c.selected_digit});
               if (!ctrl.blink_phase) begin
                  c.right_pattern = SEG_BLANK;
                  c.blink_phase   = 1'b1;
               end else begin
                  c.right_pattern = seg_of(sel_value);
                  c.blink_phase   = 1'b0;
               end
            end
            MODE_UP, MODE_DOWN: begin
               up = (c.mode == MODE_UP);
               // advance with ripple carry or borrow from the least significant digit
               for (int j = NumDigits - 1; j >= 0; j--) begin
                  if (up) begin
                     if (carry) begin
                        carry = (d[j] == DIGIT_MAX);
                        d[j]  = d[j] + 3'd1;
                     end
                  end else begin
                     if (carry) begin
                        carry = (d[j] == 3'd0);
                        d[j]  = d[j] - 3'd1;
                     end
                  end
               end
               wrap = carry;
               if (wrap) begin
                  d = digits;
                  if (ctrl.blink_phase) begin
                     c.left_pattern  = SEG_BLANK;
                     c.right_pattern = SEG_BLANK;
                     c.blink_phase   = 1'b0;
                  end else begin
                     c.left_pattern  = seg_of(3'd0);
                     c.right_pattern = seg_of(DIGIT_MAX);
                     c.blink_phase   = 1'b1;
                  end
                  steps = ctrl.blink_steps + 2'd1;
                  if (steps == 2'd3) begin
                     c.blink_steps = 2'd0;
                     c.switch_byte = SW_SELECT;
                     c.mode        = MODE_STOP;
                     c.first_start = 1'b0;
                  end else begin
                     c.blink_steps = steps;
                  end
               end
               // refresh from the most significant digit that still moves
               for (int j = 0; j < NumDigits; j++) begin
                  if (!found && (up ? (d[j] != 3'd0) : (d[j] != DIGIT_MAX))) begin
                     found           = 1'b1;
                     c.left_pattern  = seg_of(3'(j));
                     c.right_pattern = seg_of(d[j]);
                  end
               end
            end
            MODE_FILL: begin
               for (int j = 0; j < NumDigits; j++) begin
                  d[j] = DIGIT_MAX;
               end
            end
            default: begin
               c.mode = c.mode;
            end
         endcase
      end

      ctrl_next   = c;
      digits_next = d;
   end

endmodule

// File: verif/tb.sv
// Self-checking testbench for octal_counter_display_controller.
// Drives switch writes and ticks, predicts both display patterns and the switch byte.
// Depends on ocdc_pkg and the RTL under rtl/core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ocdc_pkg::*;

   localparam int N_DIG = DIGITS_DEFAULT;
   localparam int IDLE_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;
   localparam int REPORT_MAX = 10;

   localparam logic [6:0] GLYPH [8] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07
   };

   typedef struct packed {
      logic       cmd;
      logic [7:0] value;
      logic       typed;
      rsp_type    want;
   } script_row_type;

   localparam int DIRECTED_LEN = 25;
   localparam script_row_type DIRECTED [DIRECTED_LEN] = '{
      '{CMD_TICK,  8'h00,          1'b1, '{SEG_BLANK, SEG_BLANK, SW_STOP}},
      '{CMD_WRITE, SW_SELECT,      1'b1, '{SEG_BLANK, SEG_BLANK, SW_SELECT}},
      '{CMD_TICK,  8'h00,          1'b1, '{7'h3F, 7'h3F, SW_SELECT}},
      '{CMD_WRITE, SW_SELECT_LAST, 1'b1, '{7'h3F, 7'h3F, SW_SELECT_LAST}},
      '{CMD_TICK,  8'hFF,          1'b1, '{SEG_BLANK, 7'h3F, SW_SELECT_LAST}},
      '{CMD_WRITE, SW_SET_LAST,    1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_WRITE, SW_VALUE_LAST,  1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_WRITE, SW_FILL,        1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_WRITE, SW_UP,          1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_WRITE, SW_DOWN,        1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_WRITE, SW_SELECT + 8'd6, 1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_WRITE, 8'hFF,          1'b0, '0},
      '{CMD_TICK,  8'h00,          1'b0, '0},
      '{CMD_WRITE, SW_STOP,        1'b1, '{7'h3F, 7'h3F, SW_STOP}},
      '{CMD_TICK,  8'h00,          1'b0, '0}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // predicted block state
   logic [2:0] digit_reg [N_DIG];
   mode_type   cnt_mode;
   logic       blink_on;
   logic [1:0] blink_count;
   logic       started;
   logic [1:0] sel_digit;
   logic [7:0] sw_byte;
   logic [6:0] left_seg;
   logic [6:0] right_seg;

   rsp_type pending_displays [$];
   int      error_count = 0;
   int      requests_sent = 0;
   int      ticks_sent = 0;
   int      responses_seen = 0;
   int      wrap_count = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_requested = 1'b0;

   octal_counter_display_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void wrap_blink();
      if (blink_on) begin
         left_seg = SEG_BLANK;
         right_seg = SEG_BLANK;
         blink_on = 1'b0;
      end else begin
         left_seg = GLYPH[0];
         right_seg = GLYPH[DIGIT_MAX];
         blink_on = 1'b1;
      end
      blink_count = blink_count + 2'd1;
      if (blink_count == 2'd3) begin
         blink_count = 2'd0;
         sw_byte = SW_SELECT;
         cnt_mode = MODE_STOP;
         started = 1'b0;
         wrap_count++;
      end
   endfunction

   function automatic void count_step(input bit up);
      logic [2:0] limit_val;
      logic [2:0] refill_val;
      int         k;
      limit_val = up ? DIGIT_MAX : 3'd0;
      refill_val = up ? 3'd0 : DIGIT_MAX;
      k = N_DIG - 1;
      while (k >= 0 && digit_reg[k] == limit_val) k--;
      if (k >= 0) begin
         digit_reg[k] = up ? digit_reg[k] + 3'd1 : digit_reg[k] - 3'd1;
         for (int j = k + 1; j < N_DIG; j++) digit_reg[j] = refill_val;
      end else begin
         wrap_blink();
      end
      for (int j = 0; j < N_DIG; j++) begin
         if (digit_reg[j] != refill_val) begin
            left_seg = GLYPH[j];
            right_seg = GLYPH[digit_reg[j]];
            break;
         end
      end
   endfunction

   function automatic void decode_switch();
      if (sw_byte == SW_STOP) begin
         cnt_mode = MODE_STOP;
      end else if (sw_byte == SW_SELECT) begin
         if (!started) begin
            left_seg = GLYPH[0];
            right_seg = GLYPH[0];
            for (int j = 0; j < N_DIG; j++) digit_reg[j] = 3'd0;
            started = 1'b1;
         end
         cnt_mode = MODE_SELECT;
      end else if (sw_byte >= SW_SET_FIRST && sw_byte <= SW_SET_LAST) begin
         cnt_mode = MODE_SET;
      end else if (sw_byte == SW_UP) begin
         cnt_mode = MODE_UP;
      end else if (sw_byte == SW_DOWN) begin
         cnt_mode = MODE_DOWN;
      end else if (sw_byte == SW_FILL) begin
         cnt_mode = MODE_FILL;
      end
   endfunction

   function automatic void run_tick();
      decode_switch();
      case (cnt_mode)
         MODE_SELECT: begin
            if (sw_byte >= SW_SELECT && sw_byte <= SW_SELECT_LAST
                && int'(sw_byte - SW_SELECT) < N_DIG)
               sel_digit = sw_byte[1:0];
            if (!blink_on) begin
               left_seg = SEG_BLANK;
               blink_on = 1'b1;
            end else begin
               left_seg = GLYPH[sel_digit];
               blink_on = 1'b0;
            end
         end
         MODE_SET: begin
            if (sw_byte >= SW_SET_FIRST && sw_byte <= SW_VALUE_LAST)
               digit_reg[sel_digit] = sw_byte[2:0];
            left_seg = GLYPH[sel_digit];
            if (!blink_on) begin
               right_seg = SEG_BLANK;
               blink_on = 1'b1;
            end else begin
               right_seg = GLYPH[digit_reg[sel_digit]];
               blink_on = 1'b0;
            end
         end
         MODE_UP: count_step(1'b1);
         MODE_DOWN: count_step(1'b0);
         MODE_FILL: for (int j = 0; j < N_DIG; j++) digit_reg[j] = DIGIT_MAX;
         default: ;
      endcase
   endfunction

   function automatic rsp_type apply_request(input req_type r);
      rsp_type result;
      if (r.cmd == CMD_WRITE) sw_byte = r.switch_value;
      else run_tick();
      result.left_segments = left_seg;
      result.right_segments = right_seg;
      result.switch_readback = sw_byte;
      return result;
   endfunction

   function automatic logic [7:0] pick_switch_code();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return SW_SELECT;
      if (roll < 22) return SW_SELECT + 8'($urandom_range(1, 7));
      if (roll < 40) return SW_SET_FIRST + 8'($urandom_range(0, 7));
      if (roll < 55) return SW_UP;
      if (roll < 70) return SW_DOWN;
      if (roll < 78) return SW_FILL;
      if (roll < 84) return SW_STOP;
      return 8'($urandom());
   endfunction

   function automatic void check_display(input rsp_type got);
      rsp_type want;
      responses_seen++;
      if (pending_displays.size() == 0) begin
         if (error_count < REPORT_MAX)
            $display("unexpected response: left=%h right=%h switch=%h",
                     got.left_segments, got.right_segments, got.switch_readback);
         error_count++;
      end else begin
         want = pending_displays.pop_front();
         if (got.left_segments !== want.left_segments
             || got.right_segments !== want.right_segments
             || got.switch_readback !== want.switch_readback) begin
            if (error_count < REPORT_MAX)
               $display("mismatch: expected left=%h right=%h switch=%h",
                        want.left_segments, want.right_segments, want.switch_readback,
                        ", got left=%h right=%h switch=%h",
                        got.left_segments, got.right_segments, got.switch_readback);
            error_count++;
         end
      end
   endfunction

   task automatic offer(input req_type r, input logic typed, input rsp_type want);
      rsp_type predicted;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = apply_request(r);
      pending_displays.push_back(typed ? want : predicted);
      requests_sent++;
      if (r.cmd == CMD_TICK) ticks_sent++;
   endtask

   task automatic drain_and_wait();
      req_valid <= 1'b0;
      while (pending_displays.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int n_items, input int send_pct, input int recv_pct);
      int sent;
      int burst;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < n_items) begin
         offer('{CMD_WRITE, pick_switch_code()}, 1'b0, '0);
         sent++;
         if ($urandom_range(0, 99) < 6) continue;
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         repeat (burst) begin
            offer('{CMD_TICK, 8'($urandom())}, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      blink_on = 1'b1;
      blink_count = 2'd0;
      started = 1'b0;
      sel_digit = 2'd0;
      sw_byte = 8'd0;
      left_seg = SEG_BLANK;
      right_seg = SEG_BLANK;
      cnt_mode = MODE_NONE;
      for (int j = 0; j < N_DIG; j++) digit_reg[j] = 3'd0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i])
         offer('{DIRECTED[i].cmd, DIRECTED[i].value}, DIRECTED[i].typed, DIRECTED[i].want);
      run_phase(150, 10, 48);
      run_phase(250, 10, 48);
      run_phase(200, 48, 10);
      drain_and_wait();
      run_phase(200, 48, 10);
      run_phase(200, 0, 0);
      hold_requested = 1'b1;
      run_phase(200, 0, 0);
      drain_and_wait();
      repeat (10) @(posedge clock);
      $display("Sent %0d requests (%0d ticks), checked %0d responses.",
               requests_sent, ticks_sent, responses_seen);
      $display("Counter wrapped through the full blink sequence %0d times, %0d errors.",
               wrap_count, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_display(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_requested) begin
            hold_requested = 1'b0;
            stall_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
